>>> design/pattern_hyphenation_macros.svh
// ----------------------------------------------------------------------------
// Pattern hyphenation assertion macros
// Shorthand for clocked, reset-qualified assertions used in the top level.
// ----------------------------------------------------------------------------
`ifndef PATTERN_HYPHENATION_MACROS_SVH
`define PATTERN_HYPHENATION_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PH_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PH_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> design/ph_pkg.sv
// ----------------------------------------------------------------------------
// Pattern hyphenation package
// Command and status codes, fixed constants and the controller state type.
// ----------------------------------------------------------------------------
package ph_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_PATTERN = 2'd1;
  localparam logic [1:0] CMD_LETTER  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_PAT_REJECT = 2'd1;
  localparam logic [1:0] ST_WORD_LONG  = 2'd2;

  localparam logic [7:0] FRAME_DOT = 8'h2E;
  localparam int         FIRST_POS = 3;
  localparam int         LEN_W     = 5;
  localparam int         POS_W     = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_HINIT,
    S_LD_RD,
    S_LD_WR,
    S_PL_RD,
    S_PL_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_NEXT_PAT,
    S_W_RD,
    S_W_UPD,
    S_NEXT_POS,
    S_SC_RD,
    S_SC_CHK,
    S_FLUSH
  } state_t;

endpackage

>>> design/ph_if.sv
// ----------------------------------------------------------------------------
// Pattern hyphenation channels
// Valid/ready interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface ph_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] letter;
  logic [7:0] weight;
  logic       last;

  modport source (output valid, command, letter, weight, last, input ready);
  modport sink   (input valid, command, letter, weight, last, output ready);
endinterface

interface ph_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] break_position;
  logic       has_break;
  logic [1:0] status;
  logic       last_result;

  modport source (output valid, break_position, has_break, status, last_result,
                  input ready);
  modport sink   (input valid, break_position, has_break, status, last_result,
                  output ready);
endinterface

>>> design/pattern_hyphenation.sv
// ----------------------------------------------------------------------------
// Pattern hyphenation engine
// Liang-style hyphenation over a loadable pattern table held in block RAM.
// ----------------------------------------------------------------------------
// Pattern beats (clear, pattern element, closing element) and word letters
// other than the last are accepted without wait states; a closing element
// yields one status beat and keeps the input closed until that beat has
// entered the output register. The last letter of a word that fits starts
// the hyphenation pass (a longer word yields a word-too-long status beat),
// which walks every framed substring shorter than MAX_PAT_LEN against the
// stored patterns, up to the first match, through one read port per memory.
// After a setup step each substring is loaded letter by letter (read,
// write); each candidate pattern has its length read and checked, one of
// equal length is compared letter by letter (read, check), a mismatch
// advances to the next candidate and a match updates the position weights
// (read, update). Break scanning (read, check) follows, with any output
// stalls. No new beat is accepted during the pass. The position-weight
// store is cleared per word through flip-flop valid bits, so no clearing
// pass is needed; the pattern and word stores have no reset.
// ----------------------------------------------------------------------------
module pattern_hyphenation #(
  parameter int MAX_PATTERNS = 4096,
  parameter int MAX_PAT_LEN  = 16,
  parameter int MAX_WORD     = 64,
  parameter int MAX_BREAKS   = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  ph_in_if.sink    in_bus,
  ph_out_if.source out_bus
);

  `include "pattern_hyphenation_macros.svh"

  localparam int PL     = MAX_PAT_LEN;
  localparam int PWL    = MAX_PAT_LEN + 1;
  localparam int LDEPTH = MAX_PATTERNS * PL;
  localparam int WDEPTH = MAX_PATTERNS * PWL;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int WAW    = $clog2(WDEPTH);
  localparam int PIW    = $clog2(MAX_PATTERNS);
  localparam int PCW    = $clog2(MAX_PATTERNS + 1);
  localparam int SW     = $clog2(MAX_PAT_LEN + 1);
  localparam int SUBN   = MAX_PAT_LEN - 1;
  localparam int SUBW   = (SUBN > 1) ? $clog2(SUBN) : 1;
  localparam int WMW    = $clog2(MAX_WORD);
  localparam int WLW    = $clog2(MAX_WORD + 2);
  localparam int PWD    = MAX_WORD + 3;
  localparam int FW     = $clog2(PWD);
  localparam int SUMW   = FW + SW;
  localparam int KW     = $clog2(MAX_BREAKS + 1);
  localparam int LW     = ph_pkg::LEN_W;
  localparam int OPW    = ph_pkg::POS_W;

  // Memories. Only entries that were written are ever used.
  logic [7:0]    let_mem [LDEPTH];
  logic [7:0]    wt_mem  [WDEPTH];
  logic [LW-1:0] len_mem [MAX_PATTERNS];
  logic [7:0]    word_mem[MAX_WORD];
  logic [7:0]    pw_mem  [PWD];

  logic [7:0]    let_rd_r, wt_rd_r, word_rd_r, pw_rd_r;
  logic [LW-1:0] len_rd_r;

  ph_pkg::state_t state_r, state_nxt;

  logic [PCW-1:0] pcount_r, pcount_nxt;
  logic [SW-1:0]  lpos_r, lpos_nxt;
  logic [WLW-1:0] wlen_r, wlen_nxt;
  logic [FW-1:0]  flen_r, flen_nxt;
  logic [SW-1:0]  size_r, size_nxt;
  logic [FW-1:0]  pos_r, pos_nxt;
  logic [SW-1:0]  j_r, j_nxt;
  logic [PIW-1:0] p_r, p_nxt;
  logic [7:0]     sub_r[SUBN];
  logic [7:0]     sub_nxt[SUBN];
  logic [PWD-1:0] pwv_r, pwv_nxt;
  logic [FW-1:0]  i_r, i_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [OPW-1:0] pend_r, pend_nxt;
  logic           have_pend_r, have_pend_nxt;
  logic [1:0]     resp_st_r, resp_st_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [OPW-1:0] out_pos_r, out_pos_nxt;
  logic           out_hb_r, out_hb_nxt;
  logic [1:0]     out_st_r, out_st_nxt;
  logic           out_last_r, out_last_nxt;

  // Handshake and decode.
  logic in_acc, out_ok;
  logic is_clear, is_pat, is_let;
  assign in_bus.ready = (state_r == ph_pkg::S_IDLE);
  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_ok   = !out_valid_r || out_bus.ready;
  assign is_clear = in_bus.command == ph_pkg::CMD_CLEAR;
  assign is_pat   = in_bus.command == ph_pkg::CMD_PATTERN;
  assign is_let   = in_bus.command == ph_pkg::CMD_LETTER;

  // Pattern loading conditions.
  logic table_full, pat_too_long, pat_store, pat_reject;
  assign table_full   = pcount_r >= PCW'(MAX_PATTERNS);
  assign pat_too_long = lpos_r >= SW'(PL);
  assign pat_store    = in_acc && is_pat && !in_bus.last && (lpos_r < SW'(PL - 1))
                        && !table_full;
  assign pat_reject   = pat_too_long || table_full;

  // Word length after this letter.
  logic           word_fits;
  logic [WLW-1:0] wlen_new;
  assign word_fits = wlen_r < WLW'(MAX_WORD);
  assign wlen_new  = word_fits ? wlen_r + 1'b1 : WLW'(MAX_WORD + 1);

  // Matcher address arithmetic.
  logic [FW-1:0]  f_idx;
  logic [LAW-1:0] let_rd_addr, let_wr_addr;
  logic [WAW-1:0] wt_rd_addr, wt_wr_addr;
  logic [FW-1:0]  pw_rd_addr;
  logic           last_j, at_frame;
  logic [7:0]     cur_w;
  logic           pw_we, scan_go, odd_hit;
  logic           pos_done, size_done;

  assign f_idx       = pos_r + FW'(j_r);
  assign let_rd_addr = LAW'(p_r) * LAW'(PL) + LAW'(j_r);
  assign wt_rd_addr  = WAW'(p_r) * WAW'(PWL) + WAW'(j_r);
  assign let_wr_addr = LAW'(pcount_r[PIW-1:0]) * LAW'(PL) + LAW'(lpos_r);
  assign wt_wr_addr  = WAW'(pcount_r[PIW-1:0]) * WAW'(PWL) + WAW'(lpos_r);
  assign pw_rd_addr  = (state_r == ph_pkg::S_SC_RD) ? i_r : f_idx;
  assign last_j      = (j_r == size_r - 1'b1);
  assign at_frame    = (f_idx == '0) || (f_idx == flen_r - 1'b1);
  assign cur_w       = pwv_r[f_idx] ? pw_rd_r : 8'd0;
  assign pw_we       = (state_r == ph_pkg::S_W_UPD) && (wt_rd_r > cur_w);
  assign scan_go     = (SUMW'(i_r) + SUMW'(2) < SUMW'(flen_r)) && (k_r != KW'(MAX_BREAKS));
  assign odd_hit     = pwv_r[i_r] && pw_rd_r[0];
  assign pos_done    = (SUMW'(pos_r) + SUMW'(size_r) + SUMW'(1)) > SUMW'(flen_r);
  assign size_done   = (SUMW'(size_r) + SUMW'(1) > SUMW'(flen_r))
                       || (size_r + 1'b1 == SW'(PL));

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (pat_store) begin
      let_mem[let_wr_addr] <= in_bus.letter;
    end
    if (pat_store) begin
      wt_mem[wt_wr_addr] <= in_bus.weight;
    end else if (in_acc && is_pat && in_bus.last && !pat_reject && lpos_r != '0) begin
      wt_mem[wt_wr_addr] <= in_bus.weight;
    end
    if (in_acc && is_pat && in_bus.last && !pat_reject && lpos_r != '0) begin
      len_mem[pcount_r[PIW-1:0]] <= LW'(lpos_r);
    end
    if (in_acc && is_let && word_fits) begin
      word_mem[wlen_r[WMW-1:0]] <= in_bus.letter;
    end
    if (pw_we) begin
      pw_mem[f_idx] <= wt_rd_r;
    end
    let_rd_r  <= let_mem[let_rd_addr];
    wt_rd_r   <= wt_mem[wt_rd_addr];
    len_rd_r  <= len_mem[p_r];
    word_rd_r <= word_mem[WMW'(f_idx - 1'b1)];
    if (state_r == ph_pkg::S_W_RD || state_r == ph_pkg::S_SC_RD) begin
      pw_rd_r <= pw_mem[pw_rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ph_pkg::S_IDLE: begin
        if (in_acc && is_pat && in_bus.last) begin
          state_nxt = ph_pkg::S_RESP;
        end else if (in_acc && is_let && in_bus.last) begin
          state_nxt = (wlen_new > WLW'(MAX_WORD)) ? ph_pkg::S_RESP : ph_pkg::S_HINIT;
        end
      end
      ph_pkg::S_RESP:     if (out_ok) state_nxt = ph_pkg::S_IDLE;
      ph_pkg::S_HINIT:    state_nxt = ph_pkg::S_LD_RD;
      ph_pkg::S_LD_RD:    state_nxt = ph_pkg::S_LD_WR;
      ph_pkg::S_LD_WR: begin
        if (!last_j) begin
          state_nxt = ph_pkg::S_LD_RD;
        end else if (pcount_r == '0) begin
          state_nxt = ph_pkg::S_NEXT_POS;
        end else begin
          state_nxt = ph_pkg::S_PL_RD;
        end
      end
      ph_pkg::S_PL_RD:    state_nxt = ph_pkg::S_PL_CHK;
      ph_pkg::S_PL_CHK: begin
        state_nxt = (len_rd_r == LW'(size_r)) ? ph_pkg::S_CMP_RD : ph_pkg::S_NEXT_PAT;
      end
      ph_pkg::S_CMP_RD:   state_nxt = ph_pkg::S_CMP_CHK;
      ph_pkg::S_CMP_CHK: begin
        if (let_rd_r != sub_r[j_r[SUBW-1:0]]) begin
          state_nxt = ph_pkg::S_NEXT_PAT;
        end else begin
          state_nxt = last_j ? ph_pkg::S_W_RD : ph_pkg::S_CMP_RD;
        end
      end
      ph_pkg::S_NEXT_PAT: begin
        state_nxt = (PCW'(p_r) + 1'b1 == pcount_r) ? ph_pkg::S_NEXT_POS : ph_pkg::S_PL_RD;
      end
      ph_pkg::S_W_RD:     state_nxt = ph_pkg::S_W_UPD;
      ph_pkg::S_W_UPD: begin
        state_nxt = (j_r == size_r) ? ph_pkg::S_NEXT_POS : ph_pkg::S_W_RD;
      end
      ph_pkg::S_NEXT_POS: begin
        state_nxt = (pos_done && size_done) ? ph_pkg::S_SC_RD : ph_pkg::S_LD_RD;
      end
      ph_pkg::S_SC_RD:    state_nxt = scan_go ? ph_pkg::S_SC_CHK : ph_pkg::S_FLUSH;
      ph_pkg::S_SC_CHK: begin
        if (!(odd_hit && have_pend_r && !out_ok)) state_nxt = ph_pkg::S_SC_RD;
      end
      ph_pkg::S_FLUSH:    if (out_ok) state_nxt = ph_pkg::S_IDLE;
      default:            state_nxt = ph_pkg::S_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    pcount_nxt    = pcount_r;
    lpos_nxt      = lpos_r;
    wlen_nxt      = wlen_r;
    flen_nxt      = flen_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    sub_nxt       = sub_r;
    pwv_nxt       = pwv_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    resp_st_nxt   = resp_st_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_pos_nxt   = out_pos_r;
    out_hb_nxt    = out_hb_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ph_pkg::S_IDLE: begin
        if (in_acc && is_clear) begin
          pcount_nxt = '0;
          lpos_nxt   = '0;
        end else if (in_acc && is_pat && !in_bus.last) begin
          lpos_nxt = (lpos_r < SW'(PL - 1)) ? lpos_r + 1'b1 : SW'(PL);
        end else if (in_acc && is_pat) begin
          lpos_nxt    = '0;
          resp_st_nxt = pat_reject ? ph_pkg::ST_PAT_REJECT : ph_pkg::ST_OK;
          if (!pat_reject && lpos_r != '0) pcount_nxt = pcount_r + 1'b1;
        end else if (in_acc && is_let) begin
          wlen_nxt = in_bus.last ? '0 : wlen_new;
          if (in_bus.last) begin
            resp_st_nxt = ph_pkg::ST_WORD_LONG;
            flen_nxt    = FW'(wlen_new) + FW'(2);
          end
        end
      end
      ph_pkg::S_RESP: begin
        if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_hb_nxt    = 1'b0;
          out_st_nxt    = resp_st_r;
          out_last_nxt  = 1'b1;
        end
      end
      ph_pkg::S_HINIT: begin
        pwv_nxt  = '0;
        size_nxt = SW'(1);
        pos_nxt  = '0;
        j_nxt    = '0;
      end
      ph_pkg::S_LD_WR: begin
        sub_nxt[j_r[SUBW-1:0]] = at_frame ? ph_pkg::FRAME_DOT : word_rd_r;
        if (last_j) begin
          j_nxt = '0;
          p_nxt = '0;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ph_pkg::S_PL_CHK:   j_nxt = '0;
      ph_pkg::S_CMP_CHK: begin
        j_nxt = last_j ? '0 : j_r + 1'b1;
      end
      ph_pkg::S_NEXT_PAT: p_nxt = p_r + 1'b1;
      ph_pkg::S_W_UPD: begin
        if (pw_we) pwv_nxt[f_idx] = 1'b1;
        j_nxt = j_r + 1'b1;
      end
      ph_pkg::S_NEXT_POS: begin
        j_nxt   = '0;
        pos_nxt = pos_r + 1'b1;
        if (pos_done) begin
          pos_nxt  = '0;
          size_nxt = size_r + 1'b1;
        end
        i_nxt         = FW'(ph_pkg::FIRST_POS);
        k_nxt         = '0;
        have_pend_nxt = 1'b0;
      end
      ph_pkg::S_SC_CHK: begin
        if (!odd_hit) begin
          i_nxt = i_r + 1'b1;
        end else if (!have_pend_r || out_ok) begin
          if (have_pend_r) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = pend_r;
            out_hb_nxt    = 1'b1;
            out_st_nxt    = ph_pkg::ST_OK;
            out_last_nxt  = 1'b0;
          end
          pend_nxt      = OPW'(i_r - 1'b1);
          have_pend_nxt = 1'b1;
          k_nxt         = k_r + 1'b1;
          i_nxt         = i_r + 1'b1;
        end
      end
      ph_pkg::S_FLUSH: begin
        if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = have_pend_r ? pend_r : '0;
          out_hb_nxt    = have_pend_r;
          out_st_nxt    = ph_pkg::ST_OK;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ph_pkg::S_IDLE;
      pcount_r    <= '0;
      lpos_r      <= '0;
      wlen_r      <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      pwv_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pcount_r    <= pcount_nxt;
      lpos_r      <= lpos_nxt;
      wlen_r      <= wlen_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      pwv_r       <= pwv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flen_r     <= flen_nxt;
    size_r     <= size_nxt;
    pos_r      <= pos_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    sub_r      <= sub_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    resp_st_r  <= resp_st_nxt;
    out_pos_r  <= out_pos_nxt;
    out_hb_r   <= out_hb_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.break_position = out_pos_r;
  assign out_bus.has_break      = out_hb_r;
  assign out_bus.status         = out_st_r;
  assign out_bus.last_result    = out_last_r;

  // A word that fits must start the matching pass right after its last letter.
  `PH_ASSERT_NXT(a_word_starts, in_acc && is_let && in_bus.last && word_fits,
                 state_r == ph_pkg::S_HINIT, "word end did not start hyphenation")
  // Letter comparison never runs past the substring being matched.
  `PH_ASSERT_IMP(a_cmp_in_range, state_r == ph_pkg::S_CMP_CHK, j_r < size_r,
                 "letter compare index beyond substring")
  // A no-break result always carries a zero position.
  `PH_ASSERT_IMP(a_nobreak_zero, out_valid_r && !out_hb_r, out_pos_r == '0,
                 "no-break result with nonzero position")

endmodule

>>> tb/sv/tb_pattern_hyphenation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern hyphenation engine testbench
// Loads pattern tables and hyphenates words through the valid/ready channels.
// An in-bench predictor computes the expected result beats and a checker compares them.
// ----------------------------------------------------------------------------
module tb_pattern_hyphenation;

  localparam int MAX_PATTERNS = 4096;
  localparam int MAX_PAT_LEN  = 16;
  localparam int MAX_WORD     = 64;
  localparam int MAX_BREAKS   = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 4000000;

  // One result beat as seen on the output channel.
  typedef struct {
    logic [5:0] break_position;
    logic       has_break;
    logic [1:0] status;
    logic       last_result;
  } break_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ph_in_if  in_bus ();
  ph_out_if out_bus ();

  pattern_hyphenation #(
    .MAX_PATTERNS(MAX_PATTERNS),
    .MAX_PAT_LEN (MAX_PAT_LEN),
    .MAX_WORD    (MAX_WORD),
    .MAX_BREAKS  (MAX_BREAKS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  always #10 clk = ~clk;

  // Predictor state: a private copy of the pattern table and word buffer.
  logic [7:0] tbl_letters [MAX_PATTERNS*MAX_PAT_LEN];
  logic [7:0] tbl_weights [MAX_PATTERNS*(MAX_PAT_LEN+1)];
  int         tbl_lengths [MAX_PATTERNS];
  int         tbl_count;
  int         load_pos;
  logic [7:0] word_buf [MAX_WORD];
  int         word_len;

  break_beat_t expected_breaks[$];

  int  mismatches = 0;
  int  beats_checked = 0;
  int  words_sent = 0;
  int  patterns_closed = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;       // no idling on either side while set
  int  hold_left = 0;      // receiver hold-off cycles still to run

  // The Liang pass: every framed substring shorter than MAX_PAT_LEN is
  // matched against same-length patterns, the first match raising the
  // per-position maxima. Odd maxima inside the word become break points.
  task automatic predict_hyphenation();
    logic [7:0]  framed [MAX_WORD+2];
    logic [7:0]  maxima [MAX_WORD+3];
    break_beat_t found_breaks [MAX_BREAKS];
    break_beat_t beat;
    int flen, hit, k;
    bit same;
    flen = word_len + 2;
    framed[0] = ph_pkg::FRAME_DOT;
    for (int i = 0; i < word_len; i++) framed[i+1] = word_buf[i];
    framed[word_len+1] = ph_pkg::FRAME_DOT;
    foreach (maxima[i]) maxima[i] = 8'd0;
    for (int size = 1; size <= flen && size < MAX_PAT_LEN; size++) begin
      for (int pos = 0; pos + size <= flen; pos++) begin
        hit = -1;
        for (int p = 0; p < tbl_count && hit < 0; p++) begin
          if (tbl_lengths[p] == size) begin
            same = 1'b1;
            for (int j = 0; j < size; j++)
              if (tbl_letters[p*MAX_PAT_LEN+j] != framed[pos+j]) same = 1'b0;
            if (same) hit = p;
          end
        end
        if (hit >= 0) begin
          for (int j = 0; j <= size; j++)
            if (tbl_weights[hit*(MAX_PAT_LEN+1)+j] > maxima[pos+j])
              maxima[pos+j] = tbl_weights[hit*(MAX_PAT_LEN+1)+j];
        end
      end
    end
    k = 0;
    for (int i = ph_pkg::FIRST_POS; i + 2 < flen && k < MAX_BREAKS; i++) begin
      if (maxima[i][0]) begin
        found_breaks[k] = '{6'(i - 1), 1'b1, ph_pkg::ST_OK, 1'b0};
        k++;
      end
    end
    if (k == 0) begin
      beat = '{6'd0, 1'b0, ph_pkg::ST_OK, 1'b1};
      expected_breaks.push_back(beat);
    end else begin
      found_breaks[k-1].last_result = 1'b1;
      for (int i = 0; i < k; i++) expected_breaks.push_back(found_breaks[i]);
    end
  endtask

  // Updates the predictor for one accepted input beat.
  task automatic predict_beat(logic [1:0] cmd, logic [7:0] letter, logic [7:0] weight,
                              logic last);
    break_beat_t beat;
    case (cmd)
      ph_pkg::CMD_CLEAR: begin
        tbl_count = 0;
        load_pos  = 0;
      end
      ph_pkg::CMD_PATTERN: begin
        if (!last) begin
          if (load_pos < MAX_PAT_LEN - 1) begin
            if (tbl_count < MAX_PATTERNS) begin
              tbl_letters[tbl_count*MAX_PAT_LEN+load_pos]     = letter;
              tbl_weights[tbl_count*(MAX_PAT_LEN+1)+load_pos] = weight;
            end
            load_pos++;
          end else begin
            load_pos = MAX_PAT_LEN;
          end
        end else begin
          if (load_pos >= MAX_PAT_LEN || tbl_count >= MAX_PATTERNS) begin
            beat = '{6'd0, 1'b0, ph_pkg::ST_PAT_REJECT, 1'b1};
          end else begin
            if (load_pos != 0) begin
              tbl_weights[tbl_count*(MAX_PAT_LEN+1)+load_pos] = weight;
              tbl_lengths[tbl_count] = load_pos;
              tbl_count++;
            end
            beat = '{6'd0, 1'b0, ph_pkg::ST_OK, 1'b1};
          end
          load_pos = 0;
          expected_breaks.push_back(beat);
          patterns_closed++;
        end
      end
      ph_pkg::CMD_LETTER: begin
        if (word_len < MAX_WORD) begin
          word_buf[word_len] = letter;
          word_len++;
        end else begin
          word_len = MAX_WORD + 1;
        end
        if (last) begin
          if (word_len > MAX_WORD) begin
            beat = '{6'd0, 1'b0, ph_pkg::ST_WORD_LONG, 1'b1};
            expected_breaks.push_back(beat);
          end else begin
            predict_hyphenation();
          end
          word_len = 0;
          words_sent++;
        end
      end
      default: ;  // the unused command is dropped by the block
    endcase
  endtask

  // Offers one beat, waits for the handshake, then feeds the predictor.
  // Valid drops at the next falling edge; a following beat without a random gap
  // raises it again in the same time step, so back-to-back beats leave no idle gap.
  task automatic send_beat(logic [1:0] cmd, logic [7:0] letter, logic [7:0] weight,
                           logic last);
    int gap;
    if (!quiet && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 6);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.command = cmd;
    in_bus.letter  = letter;
    in_bus.weight  = weight;
    in_bus.last    = last;
    do @(posedge clk); while (!in_bus.ready);
    predict_beat(cmd, letter, weight, last);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic send_pattern(string letters, logic [7:0] weights[]);
    for (int i = 0; i < letters.len(); i++)
      send_beat(ph_pkg::CMD_PATTERN, letters[i], weights[i], 1'b0);
    send_beat(ph_pkg::CMD_PATTERN, 8'($urandom), weights[letters.len()], 1'b1);
  endtask

  task automatic send_word(string letters);
    for (int i = 0; i < letters.len(); i++)
      send_beat(ph_pkg::CMD_LETTER, letters[i], 8'($urandom), i == letters.len() - 1);
  endtask

  // Random letter, biased toward a tiny alphabet so that patterns match.
  function automatic logic [7:0] pick_letter();
    case ($urandom_range(9))
      0:       return ph_pkg::FRAME_DOT;
      1:       return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  // Receiver: random stalls, a quiet stretch, and a counted hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Checker: every accepted result beat is held against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      break_beat_t want;
      if (expected_breaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: pos %0d brk %0b st %0d last %0b",
                   out_bus.break_position, out_bus.has_break, out_bus.status,
                   out_bus.last_result);
      end else begin
        want = expected_breaks.pop_front();
        beats_checked++;
        if (out_bus.break_position !== want.break_position ||
            out_bus.has_break !== want.has_break || out_bus.status !== want.status ||
            out_bus.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected pos %0d brk %0b st %0d last %0b, got %0d %0b %0d %0b",
                     want.break_position, want.has_break, want.status, want.last_result,
                     out_bus.break_position, out_bus.has_break, out_bus.status,
                     out_bus.last_result);
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d result beats outstanding", expected_breaks.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Short patterns with dots, an empty pattern, weights at both extremes and
  // a pattern that overflows MAX_PAT_LEN.
  task automatic test_pattern_load();
    send_beat(ph_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 1'b1);
    send_pattern(".ab", '{8'd0, 8'd0, 8'd1, 8'd0});
    send_pattern("bc", '{8'd2, 8'd3, 8'd0});
    send_pattern("a", '{8'd255, 8'd254});
    send_pattern("", '{8'd7});
    send_pattern("aaaaaaaaaaaaaaaa", '{17{8'd1}});
  endtask

  // Words at the letter extremes, the dropped command, a word capped at the
  // break limit and one letter too many, the long words without idling.
  task automatic test_words();
    send_beat(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_word("abcab");
    send_word("a");
    send_beat(ph_pkg::CMD_LETTER, 8'h00, 8'h00, 1'b0);
    send_beat(ph_pkg::CMD_LETTER, 8'hFF, 8'hFF, 1'b1);
    send_beat(ph_pkg::CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_pattern("a", '{8'd1, 8'd1});
    quiet = 1'b1;
    send_word({36{"a"}});
    send_word({(MAX_WORD + 1){"a"}});
    quiet = 1'b0;
  endtask

  // The receiver holds off while status beats keep coming, so the block's
  // output backs up and it must stall the input channel.
  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 60;
    @(negedge clk);
    for (int i = 0; i < 10; i++)
      send_beat(ph_pkg::CMD_PATTERN, 8'($urandom), 8'($urandom), 1'b1);
  endtask

  // Mostly well-formed pattern loads and words over a small alphabet, with
  // occasional clears, stray commands and random bytes.
  task automatic test_random();
    int plen, wlen, n;
    n = 0;
    while (n < 20) begin
      case ($urandom_range(9))
        0: begin
          send_beat(CMD_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
          n++;
        end
        1, 2, 3, 4: begin
          if (tbl_count > 40)
            send_beat(ph_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom),
                      1'($urandom_range(1)));
          plen = $urandom_range(1, 4);
          for (int i = 0; i < plen; i++)
            send_beat(ph_pkg::CMD_PATTERN, pick_letter(), 8'($urandom_range(5)), 1'b0);
          send_beat(ph_pkg::CMD_PATTERN, 8'($urandom), 8'($urandom_range(5)), 1'b1);
          n += plen + 1;
        end
        default: begin
          wlen = $urandom_range(1, 12);
          for (int i = 0; i < wlen; i++)
            send_beat(ph_pkg::CMD_LETTER, pick_letter(), 8'($urandom), i == wlen - 1);
          n += wlen;
        end
      endcase
    end
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.command = ph_pkg::CMD_CLEAR;
    in_bus.letter  = 8'h00;
    in_bus.weight  = 8'h00;
    in_bus.last    = 1'b0;
    out_bus.ready  = 1'b0;
    tbl_count = 0;
    load_pos  = 0;
    word_len  = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_pattern_load();
    test_words();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_breaks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d words and %0d pattern closes, %0d result beats checked.",
             words_sent, patterns_closed, beats_checked);
    $display("Included overlong patterns and words, a capped break list and output hold-off.");
    if (mismatches == 0 && expected_breaks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ph_pkg.sv
design/ph_if.sv
design/pattern_hyphenation.sv
tb/sv/tb_pattern_hyphenation.sv
